[rtl/ipv4ih_pkg.sv]
`timescale 1ns / 1ps

package ipv4ih_pkg;

  // Widths of the configuration registers and the payload fields.
  localparam int unsigned MacW    = 48;
  localparam int unsigned Ipv4W   = 32;
  localparam int unsigned WordW   = 16;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 48;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DEST_MAC    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SOURCE_MAC  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SOURCE_IPV4 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DEST_IPV4   = 2'd3;

  // Header layout: word positions within the 34-byte header.
  localparam logic [IdxW-1:0] W_DMAC_HI  = 5'd0;
  localparam logic [IdxW-1:0] W_DMAC_MID = 5'd1;
  localparam logic [IdxW-1:0] W_DMAC_LO  = 5'd2;
  localparam logic [IdxW-1:0] W_SMAC_HI  = 5'd3;
  localparam logic [IdxW-1:0] W_SMAC_MID = 5'd4;
  localparam logic [IdxW-1:0] W_SMAC_LO  = 5'd5;
  localparam logic [IdxW-1:0] W_ETYPE    = 5'd6;
  localparam logic [IdxW-1:0] W_VER_IHL  = 5'd7;
  localparam logic [IdxW-1:0] W_TOT_LEN  = 5'd8;
  localparam logic [IdxW-1:0] W_IDENT    = 5'd9;
  localparam logic [IdxW-1:0] W_FLAGS    = 5'd10;
  localparam logic [IdxW-1:0] W_TTL_PROT = 5'd11;
  localparam logic [IdxW-1:0] W_CSUM     = 5'd12;
  localparam logic [IdxW-1:0] W_SIP_HI   = 5'd13;
  localparam logic [IdxW-1:0] W_SIP_LO   = 5'd14;
  localparam logic [IdxW-1:0] W_DIP_HI   = 5'd15;
  localparam logic [IdxW-1:0] W_DIP_LO   = 5'd16;
  localparam logic [IdxW-1:0] W_LAST     = W_DIP_LO;

  // Fixed header words.
  localparam logic [WordW-1:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [WordW-1:0] IPV4_VER_IHL   = 16'h4500;
  localparam logic [WordW-1:0] FLAG_DONT_FRAG = 16'h4000;
  localparam logic [WordW-1:0] TTL_PROTO      = 16'h8001;
  localparam logic [WordW-1:0] IPV4_HDR_BYTES = 16'd20;

endpackage

[rtl/ipv4_icmp_header_builder.sv]
`timescale 1ns / 1ps

// Ethernet II plus IPv4 header generator for ICMP frames. Each input beat
// carries the ICMP message length; the block answers with seventeen output
// beats, the 34-byte header as big-endian 16-bit words numbered 0 to 16, with
// last_word_o set on word 16. The header carries the configured MAC and IPv4
// addresses, ethertype 0x0800, version 4 / IHL 5, TOS 0, a total length of
// (20 + payload length) modulo 2^16, an identification that starts at 0 after
// reset and steps by one per frame with wrap, the don't-fragment flag, TTL
// 128, protocol 1 and the ones'-complement header checksum. Words leave
// through a single output word register; without stalls frames follow each
// other with no gap, since the next request is taken in the cycle the last
// word of the current frame moves into the output register. The
// configuration registers may only be written while no frame is in progress.
module ipv4_icmp_header_builder
  import ipv4ih_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WordW-1:0]   payload_length_i,
  // Header word channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WordW-1:0]   header_word_o,
  output logic [IdxW-1:0]    word_index_o,
  output logic               last_word_o
);

  // Configuration registers.
  logic [MacW-1:0]  dest_mac_q, source_mac_q;
  logic [Ipv4W-1:0] source_ipv4_q, dest_ipv4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_mac_q    <= '0;
      source_mac_q  <= '0;
      source_ipv4_q <= '0;
      dest_ipv4_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEST_MAC:    dest_mac_q    <= cfg_wdata_i[MacW-1:0];
        REG_SOURCE_MAC:  source_mac_q  <= cfg_wdata_i[MacW-1:0];
        REG_SOURCE_IPV4: source_ipv4_q <= cfg_wdata_i[Ipv4W-1:0];
        REG_DEST_IPV4:   dest_ipv4_q   <= cfg_wdata_i[Ipv4W-1:0];
        default: ;
      endcase
    end
  end

  // Frame register: the request being sent, with its own identification and
  // the position of the next word to load into the output register.
  logic              frame_valid_q;
  logic [IdxW-1:0]   cnt_q;
  logic [WordW-1:0]  tot_len_q;
  logic [WordW-1:0]  ident_q;
  logic [WordW-1:0]  ident_ctr_q;
  logic [WordW-1:0]  csum_q;

  logic              out_valid_q;
  logic [WordW-1:0]  word_q;
  logic [IdxW-1:0]   idx_q;
  logic              last_q;

  logic in_accept;
  logic advance;
  logic frame_done;

  // A word moves forward whenever the output register is empty or its beat
  // is taken in this cycle. The frame slot frees when its last word moves.
  assign advance    = frame_valid_q && (!out_valid_q || !out_stall_i);
  assign frame_done = advance && (cnt_q == W_LAST);
  assign in_stall_o = frame_valid_q && !frame_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= 1'b0;
      cnt_q         <= '0;
      ident_ctr_q   <= '0;
    end else begin
      if (in_accept) begin
        frame_valid_q <= 1'b1;
        cnt_q         <= '0;
        ident_ctr_q   <= ident_ctr_q + 16'd1;
      end else if (frame_done) begin
        frame_valid_q <= 1'b0;
      end else if (advance) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tot_len_q <= payload_length_i + IPV4_HDR_BYTES;
      ident_q   <= ident_ctr_q;
    end
  end

  // Header checksum. It is computed after the request is captured and is
  // needed no earlier than word 12, so it gets a register of its own.
  // Nine 16-bit terms fit in 20 bits; two end-around folds bring the sum back
  // to 16 bits before the inversion.
  logic [19:0]      csum_sum;
  logic [16:0]      csum_fold1;
  logic [16:0]      csum_fold2;
  logic [WordW-1:0] csum_d;

  always_comb begin
    csum_sum = {4'd0, IPV4_VER_IHL} + {4'd0, tot_len_q} + {4'd0, ident_q}
             + {4'd0, FLAG_DONT_FRAG} + {4'd0, TTL_PROTO}
             + {4'd0, source_ipv4_q[31:16]} + {4'd0, source_ipv4_q[15:0]}
             + {4'd0, dest_ipv4_q[31:16]} + {4'd0, dest_ipv4_q[15:0]};
    csum_fold1 = {13'd0, csum_sum[19:16]} + {1'b0, csum_sum[15:0]};
    csum_fold2 = {16'd0, csum_fold1[16]} + {1'b0, csum_fold1[15:0]};
    csum_d     = ~csum_fold2[15:0];
  end

  always_ff @(posedge clk_i) begin
    csum_q <= csum_d;
  end

  // Word select for the current position.
  logic [WordW-1:0] word_d;

  always_comb begin
    case (cnt_q)
      W_DMAC_HI:  word_d = dest_mac_q[47:32];
      W_DMAC_MID: word_d = dest_mac_q[31:16];
      W_DMAC_LO:  word_d = dest_mac_q[15:0];
      W_SMAC_HI:  word_d = source_mac_q[47:32];
      W_SMAC_MID: word_d = source_mac_q[31:16];
      W_SMAC_LO:  word_d = source_mac_q[15:0];
      W_ETYPE:    word_d = ETHERTYPE_IPV4;
      W_VER_IHL:  word_d = IPV4_VER_IHL;
      W_TOT_LEN:  word_d = tot_len_q;
      W_IDENT:    word_d = ident_q;
      W_FLAGS:    word_d = FLAG_DONT_FRAG;
      W_TTL_PROT: word_d = TTL_PROTO;
      W_CSUM:     word_d = csum_q;
      W_SIP_HI:   word_d = source_ipv4_q[31:16];
      W_SIP_LO:   word_d = source_ipv4_q[15:0];
      W_DIP_HI:   word_d = dest_ipv4_q[31:16];
      W_DIP_LO:   word_d = dest_ipv4_q[15:0];
      default:    word_d = '0;
    endcase
  end

  // Output register: holds one beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q <= word_d;
      idx_q  <= cnt_q;
      last_q <= (cnt_q == W_LAST);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign header_word_o = word_q;
  assign word_index_o  = idx_q;
  assign last_word_o   = last_q;

  // The word position never runs past the last header word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_q |-> (cnt_q <= W_LAST))
    else $error("word position past end of header");

  // A captured request starts at word 0 and takes the next identification.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> frame_valid_q && (cnt_q == '0)
                  && (ident_ctr_q == $past(ident_ctr_q) + 16'd1))
    else $error("request capture went wrong");

  // While the output side is stalled, the frame does not move forward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_q && out_valid_q && out_stall_i) |=> $stable(cnt_q))
    else $error("word position moved during stall");

  // The last-word flag marks exactly word 16.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == W_LAST)))
    else $error("last-word flag does not match word position");

  // A request is never taken while a frame still has words to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_q && (cnt_q != W_LAST)) |-> in_stall_o)
    else $error("request taken in the middle of a frame");

endmodule
